// ----- sv/stok_pkg.sv -----
// ----------------------------------------------------------------------------
// stok_pkg: shared types, constants and functions of the source tokenizer
// Token kinds, scanner phases, byte classes, the classified input item, the
// result token, the byte classifier and the keyword lookup.
// ----------------------------------------------------------------------------
package stok_pkg;

	localparam int POS_BITS_DEF = 16;
	localparam int KW_CHARS     = 8;
	localparam int KW_IDX       = $clog2(KW_CHARS);
	localparam int ITEM_DEPTH   = 4;
	localparam int TOK_DEPTH    = 4;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;

	typedef enum logic [5:0] {
		TK_END      = 6'd0,
		TK_NUMBER   = 6'd1,
		TK_IDENT    = 6'd2,
		TK_STRING   = 6'd3,
		TK_TRUE     = 6'd4,
		TK_FALSE    = 6'd5,
		TK_NULL     = 6'd6,
		TK_IF       = 6'd7,
		TK_ELSE     = 6'd8,
		TK_WHILE    = 6'd9,
		TK_FOR      = 6'd10,
		TK_RETURN   = 6'd11,
		TK_BREAK    = 6'd12,
		TK_CONTINUE = 6'd13,
		TK_LET      = 6'd14,
		TK_FUN      = 6'd15,
		TK_PLUS     = 6'd16,
		TK_MINUS    = 6'd17,
		TK_ARROW    = 6'd18,
		TK_STAR     = 6'd19,
		TK_SLASH    = 6'd20,
		TK_LPAREN   = 6'd21,
		TK_RPAREN   = 6'd22,
		TK_LBRACE   = 6'd23,
		TK_RBRACE   = 6'd24,
		TK_LBRACKET = 6'd25,
		TK_RBRACKET = 6'd26,
		TK_COMMA    = 6'd27,
		TK_COLON    = 6'd28,
		TK_SEMI     = 6'd29,
		TK_ASSIGN   = 6'd30,
		TK_EQ       = 6'd31,
		TK_BANG     = 6'd32,
		TK_NE       = 6'd33,
		TK_LT       = 6'd34,
		TK_LE       = 6'd35,
		TK_SHL      = 6'd36,
		TK_GT       = 6'd37,
		TK_GE       = 6'd38,
		TK_SHR      = 6'd39,
		TK_AMP      = 6'd40,
		TK_ANDAND   = 6'd41,
		TK_BAR      = 6'd42,
		TK_OROR     = 6'd43,
		TK_BADCHAR  = 6'd44,
		TK_UNTERM   = 6'd45
	} tok_kind_t;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_NUM,
		PH_IDENT,
		PH_STR,
		PH_COMMENT,
		PH_ERROR,
		PH_MINUS,
		PH_EQ,
		PH_BANG,
		PH_LT,
		PH_GT,
		PH_AMP,
		PH_BAR,
		PH_SLASH
	} phase_t;

	typedef enum logic [2:0] {
		CL_BLANK,
		CL_NEWLINE,
		CL_DIGIT,
		CL_ALPHA,
		CL_QUOTE,
		CL_SINGLE,
		CL_PEND,
		CL_BAD
	} char_class_t;

	typedef struct packed {
		logic        mode;
		logic [7:0]  text_byte;
		char_class_t cls;
		tok_kind_t   kind;
		phase_t      pend;
	} item_t;

	typedef struct packed {
		tok_kind_t   kind;
		logic [15:0] start_offset;
		logic [15:0] text_length;
		logic [15:0] line_number;
		logic [15:0] column_number;
		logic        run_last;
	} token_t;

	// Sorts one byte into the class that the scanner acts on. Single-character
	// tokens carry their kind and operator starters carry their pending phase.
	function automatic item_t classify(input logic mode, input logic [7:0] b);
		item_t it;
		it.mode      = mode;
		it.text_byte = b;
		it.cls       = CL_BAD;
		it.kind      = TK_BADCHAR;
		it.pend      = PH_IDLE;
		if (b == CH_SPACE || b == CH_TAB || b == CH_CR) begin
			it.cls = CL_BLANK;
		end else if (b == CH_LF) begin
			it.cls = CL_NEWLINE;
		end else if (b >= "0" && b <= "9") begin
			it.cls = CL_DIGIT;
		end else if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_") begin
			it.cls = CL_ALPHA;
		end else if (b == CH_QUOTE) begin
			it.cls = CL_QUOTE;
		end else begin
			unique case (b)
				";": begin it.cls = CL_SINGLE; it.kind = TK_SEMI;     end
				"+": begin it.cls = CL_SINGLE; it.kind = TK_PLUS;     end
				"*": begin it.cls = CL_SINGLE; it.kind = TK_STAR;     end
				"(": begin it.cls = CL_SINGLE; it.kind = TK_LPAREN;   end
				")": begin it.cls = CL_SINGLE; it.kind = TK_RPAREN;   end
				"{": begin it.cls = CL_SINGLE; it.kind = TK_LBRACE;   end
				"}": begin it.cls = CL_SINGLE; it.kind = TK_RBRACE;   end
				"[": begin it.cls = CL_SINGLE; it.kind = TK_LBRACKET; end
				"]": begin it.cls = CL_SINGLE; it.kind = TK_RBRACKET; end
				",": begin it.cls = CL_SINGLE; it.kind = TK_COMMA;    end
				":": begin it.cls = CL_SINGLE; it.kind = TK_COLON;    end
				"-": begin it.cls = CL_PEND;   it.pend = PH_MINUS;    end
				"=": begin it.cls = CL_PEND;   it.pend = PH_EQ;       end
				"!": begin it.cls = CL_PEND;   it.pend = PH_BANG;     end
				"<": begin it.cls = CL_PEND;   it.pend = PH_LT;       end
				">": begin it.cls = CL_PEND;   it.pend = PH_GT;       end
				"&": begin it.cls = CL_PEND;   it.pend = PH_AMP;      end
				"|": begin it.cls = CL_PEND;   it.pend = PH_BAR;      end
				"/": begin it.cls = CL_PEND;   it.pend = PH_SLASH;    end
				default: begin it.cls = CL_BAD; end
			endcase
		end
		return it;
	endfunction

	// Compares the buffered name against the twelve keywords. Only the first
	// len characters of the buffer belong to the current name.
	function automatic tok_kind_t kw_lookup(input logic [KW_CHARS-1:0][7:0] buf_in,
			input logic [KW_IDX:0] len);
		logic [8*KW_CHARS-1:0] view;
		tok_kind_t             k;
		for (int i = 0; i < KW_CHARS; i++) begin
			view[8*(KW_CHARS-1-i) +: 8] = buf_in[i];
		end
		k = TK_IDENT;
		if (len == (KW_IDX+1)'(4) && view[8*KW_CHARS-1 -: 32] == "true")     k = TK_TRUE;
		if (len == (KW_IDX+1)'(5) && view[8*KW_CHARS-1 -: 40] == "false")    k = TK_FALSE;
		if (len == (KW_IDX+1)'(4) && view[8*KW_CHARS-1 -: 32] == "null")     k = TK_NULL;
		if (len == (KW_IDX+1)'(2) && view[8*KW_CHARS-1 -: 16] == "if")       k = TK_IF;
		if (len == (KW_IDX+1)'(4) && view[8*KW_CHARS-1 -: 32] == "else")     k = TK_ELSE;
		if (len == (KW_IDX+1)'(5) && view[8*KW_CHARS-1 -: 40] == "while")    k = TK_WHILE;
		if (len == (KW_IDX+1)'(3) && view[8*KW_CHARS-1 -: 24] == "for")      k = TK_FOR;
		if (len == (KW_IDX+1)'(6) && view[8*KW_CHARS-1 -: 48] == "return")   k = TK_RETURN;
		if (len == (KW_IDX+1)'(5) && view[8*KW_CHARS-1 -: 40] == "break")    k = TK_BREAK;
		if (len == (KW_IDX+1)'(8) && view[8*KW_CHARS-1 -: 64] == "continue") k = TK_CONTINUE;
		if (len == (KW_IDX+1)'(3) && view[8*KW_CHARS-1 -: 24] == "let")      k = TK_LET;
		if (len == (KW_IDX+1)'(3) && view[8*KW_CHARS-1 -: 24] == "fun")      k = TK_FUN;
		return k;
	endfunction

endpackage

// ----- sv/source_tokenizer.sv -----
// ----------------------------------------------------------------------------
// source_tokenizer: streaming tokenizer for source text
// Turns a byte stream into tokens with kind, offset, length, line and column.
// ----------------------------------------------------------------------------
// Usage. The source channel (src_valid / src_stall, fields mode and
// text_byte) carries one source byte per transaction, or with mode set the
// end of the source. The token channel (tok_valid / tok_stall) carries one
// token per transaction; run_last marks the last token that a source
// transaction caused. Blanks, newlines and line comments give no token.
// A transaction is taken at a clock edge with valid high and stall low.
// Path: a taken byte is classified into the input queue; the scanner reads it
// from there and writes the token that it completes into the token queue.
// Throughput: one source byte per cycle. The scanner takes one byte per
// cycle from a four-entry input queue while its four-entry token queue has
// room for two tokens; a byte that ends one token and forms another yields
// two tokens, and the output side drains one token per cycle.
// Stall: while tok_stall is high the token queue fills, the scanner then
// waits, the input queue fills and src_stall rises. Nothing is lost.
// Reset: arst_n clears both queues and puts the scanner between tokens at
// offset 0, line 1, column 1. The end-of-source transaction gives the END
// token and returns the scanner to that same state for the next source.
// ----------------------------------------------------------------------------
module source_tokenizer #(
	parameter int POSITION_BITS = stok_pkg::POS_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        src_valid,
	output logic        src_stall,
	input  logic        mode,
	input  logic [7:0]  text_byte,
	output logic        tok_valid,
	input  logic        tok_stall,
	output logic [5:0]  kind,
	output logic [15:0] start_offset,
	output logic [15:0] text_length,
	output logic [15:0] line_number,
	output logic [15:0] column_number,
	output logic        run_last
);

	localparam int TW = $bits(stok_pkg::token_t);
	localparam int CW = $clog2(stok_pkg::TOK_DEPTH+1);

	stok_pkg::item_t  item;
	logic             item_valid;
	logic             item_pop;
	logic             push0;
	logic             push1;
	stok_pkg::token_t tok0;
	stok_pkg::token_t tok1;
	logic             tok_room;
	logic             tok_pop;
	logic [TW-1:0]    head_bits;
	stok_pkg::token_t head;
	logic [CW-1:0]    tok_count;

	// Front: accept and classify source bytes.
	stok_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.mode      (mode),
		.text_byte (text_byte),
		.item_valid(item_valid),
		.item      (item),
		.item_pop  (item_pop)
	);

	// The scanner only takes a byte when both of its possible tokens fit.
	assign tok_room = (tok_count <= CW'(stok_pkg::TOK_DEPTH - 2));

	// Back: scanner state machine.
	stok_scan #(
		.POS_BITS(POSITION_BITS)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item      (item),
		.item_pop  (item_pop),
		.tok_room  (tok_room),
		.push0     (push0),
		.push1     (push1),
		.tok0      (tok0),
		.tok1      (tok1)
	);

	// Token queue in front of the output channel.
	stok_fifo #(
		.WIDTH(TW),
		.DEPTH(stok_pkg::TOK_DEPTH)
	) u_tok_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push0 (push0),
		.data0 (tok0),
		.push1 (push1),
		.data1 (tok1),
		.pop   (tok_pop),
		.head  (head_bits),
		.count (tok_count)
	);

	assign head          = stok_pkg::token_t'(head_bits);
	assign tok_valid     = (tok_count != '0);
	assign tok_pop       = tok_valid && !tok_stall;
	assign kind          = head.kind;
	assign start_offset  = head.start_offset;
	assign text_length   = head.text_length;
	assign line_number   = head.line_number;
	assign column_number = head.column_number;
	assign run_last      = head.run_last;

endmodule

// ----- sv/stok_fifo.sv -----
// ----------------------------------------------------------------------------
// stok_fifo: small register queue with one or two writes per cycle
// Holds up to DEPTH entries (a power of two); the head entry is always shown.
// ----------------------------------------------------------------------------
module stok_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push0,
	input  logic [WIDTH-1:0]           data0,
	input  logic                       push1,
	input  logic [WIDTH-1:0]           data1,
	input  logic                       pop,
	output logic [WIDTH-1:0]           head,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH+1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wp_q;
	logic [AW-1:0]    rp_q;
	logic [CW-1:0]    cnt_q;

	// The second write lands just behind the first one.
	always_ff @(posedge clk) begin
		if (push0) begin
			mem_q[wp_q] <= data0;
		end
		if (push1) begin
			mem_q[wp_q + AW'(1)] <= data1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + AW'(push0) + AW'(push1);
			rp_q  <= rp_q + AW'(pop);
			cnt_q <= cnt_q + CW'(push0) + CW'(push1) - CW'(pop);
		end
	end

	assign head  = mem_q[rp_q];
	assign count = cnt_q;

endmodule

// ----- sv/stok_front.sv -----
// ----------------------------------------------------------------------------
// stok_front: input side of the tokenizer
// Accepts source transactions, classifies each byte and queues the result.
// ----------------------------------------------------------------------------
module stok_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            src_valid,
	output logic            src_stall,
	input  logic            mode,
	input  logic [7:0]      text_byte,
	output logic            item_valid,
	output stok_pkg::item_t item,
	input  logic            item_pop
);

	localparam int IW = $bits(stok_pkg::item_t);
	localparam int CW = $clog2(stok_pkg::ITEM_DEPTH+1);

	logic          push;
	logic [IW-1:0] push_bits;
	logic [IW-1:0] head_bits;
	logic [CW-1:0] count;

	assign src_stall = (count == CW'(stok_pkg::ITEM_DEPTH));
	assign push      = src_valid && !src_stall;
	assign push_bits = stok_pkg::classify(mode, text_byte);

	stok_fifo #(
		.WIDTH(IW),
		.DEPTH(stok_pkg::ITEM_DEPTH)
	) u_item_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push0 (push),
		.data0 (push_bits),
		.push1 (1'b0),
		.data1 ('0),
		.pop   (item_pop),
		.head  (head_bits),
		.count (count)
	);

	assign item_valid = (count != '0);
	assign item       = stok_pkg::item_t'(head_bits);

endmodule

// ----- sv/stok_scan.sv -----
// ----------------------------------------------------------------------------
// stok_scan: scanner state machine of the tokenizer
// Takes one classified item per cycle while tok_room holds, giving up to two tokens.
// ----------------------------------------------------------------------------
module stok_scan #(
	parameter int POS_BITS = stok_pkg::POS_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  stok_pkg::item_t  item,
	output logic             item_pop,
	input  logic             tok_room,
	output logic             push0,
	output logic             push1,
	output stok_pkg::token_t tok0,
	output stok_pkg::token_t tok1
);

	localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);
	localparam logic [POS_BITS-1:0] POS_TWO = POS_BITS'(2);

	typedef struct packed {
		logic                v;
		stok_pkg::tok_kind_t kind;
		logic [POS_BITS-1:0] start;
		logic [POS_BITS-1:0] len;
		logic [POS_BITS-1:0] line;
		logic [POS_BITS-1:0] col;
	} emit_t;

	typedef struct packed {
		stok_pkg::tok_kind_t single;
		logic [7:0]          c1;
		stok_pkg::tok_kind_t k1;
		logic                has_c2;
		stok_pkg::tok_kind_t k2;
	} pend_t;

	function automatic logic [POS_BITS-1:0] pos_inc(input logic [POS_BITS-1:0] v);
		return (v == '1) ? v : v + POS_ONE;
	endfunction

	function automatic logic [15:0] sat16(input logic [POS_BITS-1:0] v);
		logic [32:0] w;
		w = 33'(v);
		return (w > 33'h0FFFF) ? 16'hFFFF : w[15:0];
	endfunction

	function automatic emit_t mk(input stok_pkg::tok_kind_t kind,
			input logic [POS_BITS-1:0] start, input logic [POS_BITS-1:0] len,
			input logic [POS_BITS-1:0] line, input logic [POS_BITS-1:0] col);
		emit_t e;
		e.v     = 1'b1;
		e.kind  = kind;
		e.start = start;
		e.len   = len;
		e.line  = line;
		e.col   = col;
		return e;
	endfunction

	function automatic stok_pkg::token_t to_token(input emit_t e, input logic last);
		stok_pkg::token_t t;
		t.kind          = e.kind;
		t.start_offset  = sat16(e.start);
		t.text_length   = sat16(e.len);
		t.line_number   = sat16(e.line);
		t.column_number = sat16(e.col);
		t.run_last      = last;
		return t;
	endfunction

	// What a pending operator turns into, by the character that follows it.
	function automatic pend_t pend_info(input stok_pkg::phase_t ph);
		pend_t p;
		p.single = stok_pkg::TK_BADCHAR;
		p.c1     = 8'h00;
		p.k1     = stok_pkg::TK_BADCHAR;
		p.has_c2 = 1'b0;
		p.k2     = stok_pkg::TK_BADCHAR;
		unique case (ph)
			stok_pkg::PH_MINUS: begin
				p.single = stok_pkg::TK_MINUS;  p.c1 = ">"; p.k1 = stok_pkg::TK_ARROW;
			end
			stok_pkg::PH_EQ: begin
				p.single = stok_pkg::TK_ASSIGN; p.c1 = "="; p.k1 = stok_pkg::TK_EQ;
			end
			stok_pkg::PH_BANG: begin
				p.single = stok_pkg::TK_BANG;   p.c1 = "="; p.k1 = stok_pkg::TK_NE;
			end
			stok_pkg::PH_LT: begin
				p.single = stok_pkg::TK_LT;     p.c1 = "<"; p.k1 = stok_pkg::TK_SHL;
				p.has_c2 = 1'b1;                p.k2 = stok_pkg::TK_LE;
			end
			stok_pkg::PH_GT: begin
				p.single = stok_pkg::TK_GT;     p.c1 = ">"; p.k1 = stok_pkg::TK_SHR;
				p.has_c2 = 1'b1;                p.k2 = stok_pkg::TK_GE;
			end
			stok_pkg::PH_AMP: begin
				p.single = stok_pkg::TK_AMP;    p.c1 = "&"; p.k1 = stok_pkg::TK_ANDAND;
			end
			stok_pkg::PH_BAR: begin
				p.single = stok_pkg::TK_BAR;    p.c1 = "|"; p.k1 = stok_pkg::TK_OROR;
			end
			stok_pkg::PH_SLASH: begin
				p.single = stok_pkg::TK_SLASH;  p.c1 = "/";
			end
			default: begin
			end
		endcase
		return p;
	endfunction

	stok_pkg::phase_t    phase_q, phase_n;
	logic [POS_BITS-1:0] off_q, off_n;
	logic [POS_BITS-1:0] line_q, line_n;
	logic [POS_BITS-1:0] col_q, col_n;
	logic [POS_BITS-1:0] tstart_q, tstart_n;
	logic [POS_BITS-1:0] tline_q, tline_n;
	logic [POS_BITS-1:0] tcol_q, tcol_n;
	logic [POS_BITS-1:0] cnt_q, cnt_n;
	logic [stok_pkg::KW_CHARS-1:0][7:0] kwbuf_q, kwbuf_n;

	logic                do_idle;
	logic [7:0]          b;
	pend_t               pi;
	stok_pkg::tok_kind_t ident_kind;
	emit_t               e0;
	emit_t               e1;

	assign item_pop = item_valid && tok_room;
	assign b        = item.text_byte;
	assign pi       = pend_info(phase_q);
	assign ident_kind = (cnt_q > POS_BITS'(stok_pkg::KW_CHARS)) ? stok_pkg::TK_IDENT :
		stok_pkg::kw_lookup(kwbuf_q, cnt_q[stok_pkg::KW_IDX:0]);

	always_comb begin
		phase_n  = phase_q;
		off_n    = off_q;
		line_n   = line_q;
		col_n    = col_q;
		tstart_n = tstart_q;
		tline_n  = tline_q;
		tcol_n   = tcol_q;
		cnt_n    = cnt_q;
		kwbuf_n  = kwbuf_q;
		e0       = '0;
		e1       = '0;
		do_idle  = 1'b0;

		if (item_pop) begin
			if (item.mode) begin
				// End of source: flush an open token, then END, then start over.
				unique case (phase_q)
					stok_pkg::PH_NUM:
						e0 = mk(stok_pkg::TK_NUMBER, tstart_q, cnt_q, tline_q, tcol_q);
					stok_pkg::PH_IDENT:
						e0 = mk(ident_kind, tstart_q, cnt_q, tline_q, tcol_q);
					stok_pkg::PH_STR:
						e0 = mk(stok_pkg::TK_UNTERM, tstart_q, cnt_q, tline_q, tcol_q);
					stok_pkg::PH_MINUS, stok_pkg::PH_EQ, stok_pkg::PH_BANG,
					stok_pkg::PH_LT, stok_pkg::PH_GT, stok_pkg::PH_AMP,
					stok_pkg::PH_BAR, stok_pkg::PH_SLASH:
						e0 = mk(pi.single, tstart_q, cnt_q, tline_q, tcol_q);
					default: begin
					end
				endcase
				e1       = mk(stok_pkg::TK_END, off_q, '0, line_q, col_q);
				phase_n  = stok_pkg::PH_IDLE;
				off_n    = '0;
				line_n   = POS_ONE;
				col_n    = POS_ONE;
				tstart_n = '0;
				tline_n  = POS_ONE;
				tcol_n   = POS_ONE;
				cnt_n    = '0;
			end else begin
				unique case (phase_q)
					stok_pkg::PH_ERROR: begin
					end
					stok_pkg::PH_NUM: begin
						if (item.cls == stok_pkg::CL_DIGIT) begin
							cnt_n = pos_inc(cnt_q);
							off_n = pos_inc(off_q);
							col_n = pos_inc(col_q);
						end else begin
							e0      = mk(stok_pkg::TK_NUMBER, tstart_q, cnt_q, tline_q, tcol_q);
							phase_n = stok_pkg::PH_IDLE;
							do_idle = 1'b1;
						end
					end
					stok_pkg::PH_IDENT: begin
						if (item.cls == stok_pkg::CL_DIGIT || item.cls == stok_pkg::CL_ALPHA) begin
							if (cnt_q < POS_BITS'(stok_pkg::KW_CHARS)) begin
								kwbuf_n[cnt_q[stok_pkg::KW_IDX-1:0]] = b;
							end
							cnt_n = pos_inc(cnt_q);
							off_n = pos_inc(off_q);
							col_n = pos_inc(col_q);
						end else begin
							e0      = mk(ident_kind, tstart_q, cnt_q, tline_q, tcol_q);
							phase_n = stok_pkg::PH_IDLE;
							do_idle = 1'b1;
						end
					end
					stok_pkg::PH_STR: begin
						// A newline inside a string is plain content.
						if (item.cls == stok_pkg::CL_QUOTE) begin
							e0      = mk(stok_pkg::TK_STRING, tstart_q, cnt_q, tline_q, tcol_q);
							phase_n = stok_pkg::PH_IDLE;
						end else begin
							cnt_n = pos_inc(cnt_q);
						end
						off_n = pos_inc(off_q);
						col_n = pos_inc(col_q);
					end
					stok_pkg::PH_COMMENT: begin
						if (item.cls == stok_pkg::CL_NEWLINE) begin
							phase_n = stok_pkg::PH_IDLE;
							do_idle = 1'b1;
						end else begin
							off_n = pos_inc(off_q);
							col_n = pos_inc(col_q);
						end
					end
					stok_pkg::PH_MINUS, stok_pkg::PH_EQ, stok_pkg::PH_BANG,
					stok_pkg::PH_LT, stok_pkg::PH_GT, stok_pkg::PH_AMP,
					stok_pkg::PH_BAR, stok_pkg::PH_SLASH: begin
						if (b == pi.c1) begin
							off_n = pos_inc(off_q);
							col_n = pos_inc(col_q);
							if (phase_q == stok_pkg::PH_SLASH) begin
								phase_n = stok_pkg::PH_COMMENT;
							end else begin
								cnt_n   = POS_TWO;
								e0      = mk(pi.k1, tstart_q, POS_TWO, tline_q, tcol_q);
								phase_n = stok_pkg::PH_IDLE;
							end
						end else if (pi.has_c2 && b == "=") begin
							off_n   = pos_inc(off_q);
							col_n   = pos_inc(col_q);
							cnt_n   = POS_TWO;
							e0      = mk(pi.k2, tstart_q, POS_TWO, tline_q, tcol_q);
							phase_n = stok_pkg::PH_IDLE;
						end else begin
							// Not completed: give the one-character operator and
							// scan this byte afresh.
							e0      = mk(pi.single, tstart_q, cnt_q, tline_q, tcol_q);
							phase_n = stok_pkg::PH_IDLE;
							do_idle = 1'b1;
						end
					end
					default: begin
						phase_n = stok_pkg::PH_IDLE;
						do_idle = 1'b1;
					end
				endcase

				if (do_idle) begin
					unique case (item.cls)
						stok_pkg::CL_BLANK: begin
							off_n = pos_inc(off_q);
							col_n = pos_inc(col_q);
						end
						stok_pkg::CL_NEWLINE: begin
							off_n  = pos_inc(off_q);
							line_n = pos_inc(line_q);
							col_n  = POS_ONE;
						end
						default: begin
							tstart_n = off_q;
							tline_n  = line_q;
							tcol_n   = col_q;
							cnt_n    = POS_ONE;
							off_n    = pos_inc(off_q);
							col_n    = pos_inc(col_q);
							unique case (item.cls)
								stok_pkg::CL_DIGIT: begin
									phase_n = stok_pkg::PH_NUM;
								end
								stok_pkg::CL_ALPHA: begin
									kwbuf_n[0] = b;
									phase_n    = stok_pkg::PH_IDENT;
								end
								stok_pkg::CL_QUOTE: begin
									// The string text starts after the quote.
									tstart_n = pos_inc(off_q);
									cnt_n    = '0;
									phase_n  = stok_pkg::PH_STR;
								end
								stok_pkg::CL_SINGLE: begin
									e1 = mk(item.kind, off_q, POS_ONE, line_q, col_q);
								end
								stok_pkg::CL_PEND: begin
									phase_n = item.pend;
								end
								default: begin
									e1      = mk(stok_pkg::TK_BADCHAR, off_q, POS_ONE, line_q, col_q);
									phase_n = stok_pkg::PH_ERROR;
								end
							endcase
						end
					endcase
				end
			end
		end
	end

	// The earlier token goes first; run_last marks whichever comes last.
	always_comb begin
		push0 = e0.v || e1.v;
		push1 = e0.v && e1.v;
		tok0  = e0.v ? to_token(e0, !e1.v) : to_token(e1, 1'b1);
		tok1  = to_token(e1, 1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= stok_pkg::PH_IDLE;
			off_q    <= '0;
			line_q   <= POS_ONE;
			col_q    <= POS_ONE;
			tstart_q <= '0;
			tline_q  <= POS_ONE;
			tcol_q   <= POS_ONE;
			cnt_q    <= '0;
		end else begin
			phase_q  <= phase_n;
			off_q    <= off_n;
			line_q   <= line_n;
			col_q    <= col_n;
			tstart_q <= tstart_n;
			tline_q  <= tline_n;
			tcol_q   <= tcol_n;
			cnt_q    <= cnt_n;
		end
	end

	always_ff @(posedge clk) begin
		kwbuf_q <= kwbuf_n;
	end

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking testbench for the source tokenizer
// Feeds source text and end markers through the source channel and checks
// every token on the token channel against a cycle-free scanner that tracks
// phase, position and the current token on the side.
// ----------------------------------------------------------------------------
module tb;

	localparam int RANDOM_ITEMS = 1000;
	localparam int TAIL_ITEMS   = 120;   // the last items go through with no idling
	localparam int HOLD_CYCLES  = 80;    // long token-side hold-off to back up the block
	localparam int STALL_LIMIT  = 2000;  // cycles with no transaction before giving up
	localparam int DRAIN_CYCLES = 16;

	typedef struct packed {
		logic       mode;
		logic [7:0] text_byte;
		logic       rush;      // the sender does not idle in front of this byte
	} src_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        src_valid = 1'b0;
	logic        src_stall;
	logic        mode = 1'b0;
	logic [7:0]  text_byte = 8'h00;
	logic        tok_valid;
	logic        tok_stall = 1'b0;
	logic [5:0]  kind;
	logic [15:0] start_offset;
	logic [15:0] text_length;
	logic [15:0] line_number;
	logic [15:0] column_number;
	logic        run_last;

	src_item_t        source_bytes [$];
	stok_pkg::token_t tokens_due [$];
	stok_pkg::token_t step_out [$];
	int               bytes_taken = 0;
	int               n_items = 0;
	int               squeeze_at = 32'h7fffffff;
	int               mismatches = 0;
	int               idle_run = 0;
	int               src_gap = 0;
	int               sink_gap = 0;
	int               hold_left = 0;
	bit               squeezed = 1'b0;
	logic             src_took = 1'b0;

	// Scanner state kept alongside the block.
	stok_pkg::phase_t lx_phase;
	logic [15:0]      lx_off, lx_line, lx_col;
	logic [15:0]      tok_off, tok_line, tok_col, tok_len;
	logic [7:0]       name_buf [stok_pkg::KW_CHARS];

	string kw_words [12] = '{"true", "false", "null", "if", "else", "while", "for",
		"return", "break", "continue", "let", "fun"};
	string op_words [28] = '{"+", "-", "->", "*", "/", "(", ")", "{", "}", "[", "]",
		",", ":", ";", "=", "==", "!", "!=", "<", "<=", "<<", ">", ">=", ">>", "&",
		"&&", "|", "||"};
	string name_chars  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
	string digit_chars = "0123456789";

	source_tokenizer uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.src_valid     (src_valid),
		.src_stall     (src_stall),
		.mode          (mode),
		.text_byte     (text_byte),
		.tok_valid     (tok_valid),
		.tok_stall     (tok_stall),
		.kind          (kind),
		.start_offset  (start_offset),
		.text_length   (text_length),
		.line_number   (line_number),
		.column_number (column_number),
		.run_last      (run_last)
	);

	// ------------------------------------------------------------------------
	// Scanner prediction
	// ------------------------------------------------------------------------

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic bit is_digit(input logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic bit is_name(input logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
	endfunction

	// Operator starter that is left on its own when the next byte does not pair.
	function automatic stok_pkg::tok_kind_t lone_kind(input stok_pkg::phase_t p);
		case (p)
			stok_pkg::PH_MINUS: return stok_pkg::TK_MINUS;
			stok_pkg::PH_EQ:    return stok_pkg::TK_ASSIGN;
			stok_pkg::PH_BANG:  return stok_pkg::TK_BANG;
			stok_pkg::PH_LT:    return stok_pkg::TK_LT;
			stok_pkg::PH_GT:    return stok_pkg::TK_GT;
			stok_pkg::PH_AMP:   return stok_pkg::TK_AMP;
			stok_pkg::PH_BAR:   return stok_pkg::TK_BAR;
			default:            return stok_pkg::TK_SLASH;
		endcase
	endfunction

	// Names longer than the buffer can never be keywords.
	function automatic stok_pkg::tok_kind_t name_kind();
		stok_pkg::tok_kind_t k;
		bit                  same;
		k = stok_pkg::TK_IDENT;
		if (tok_len <= stok_pkg::KW_CHARS) begin
			for (int i = 0; i < 12; i++) begin
				if (kw_words[i].len() == int'(tok_len)) begin
					same = 1'b1;
					for (int j = 0; j < kw_words[i].len(); j++) begin
						if (name_buf[j] != kw_words[i][j])
							same = 1'b0;
					end
					if (same)
						k = stok_pkg::tok_kind_t'(int'(stok_pkg::TK_TRUE) + i);
				end
			end
		end
		return k;
	endfunction

	task automatic step_over();
		lx_off = sat_inc(lx_off);
		lx_col = sat_inc(lx_col);
	endtask

	task automatic put(input stok_pkg::tok_kind_t k, input logic [15:0] s,
			input logic [15:0] n, input logic [15:0] ln, input logic [15:0] cl);
		stok_pkg::token_t t;
		t.kind          = k;
		t.start_offset  = s;
		t.text_length   = n;
		t.line_number   = ln;
		t.column_number = cl;
		t.run_last      = 1'b0;
		step_out.insert(step_out.size(), t);
	endtask

	task automatic put_tok(input stok_pkg::tok_kind_t k);
		put(k, tok_off, tok_len, tok_line, tok_col);
	endtask

	task automatic lex_clear();
		lx_phase = stok_pkg::PH_IDLE;
		lx_off   = 16'd0;
		lx_line  = 16'd1;
		lx_col   = 16'd1;
		tok_off  = 16'd0;
		tok_line = 16'd1;
		tok_col  = 16'd1;
		tok_len  = 16'd0;
		foreach (name_buf[i])
			name_buf[i] = 8'h00;
	endtask

	// A byte seen between tokens.
	task automatic lex_fresh(input logic [7:0] b);
		if (b == stok_pkg::CH_SPACE || b == stok_pkg::CH_TAB || b == stok_pkg::CH_CR) begin
			step_over();
		end else if (b == stok_pkg::CH_LF) begin
			lx_off  = sat_inc(lx_off);
			lx_line = sat_inc(lx_line);
			lx_col  = 16'd1;
		end else begin
			tok_off  = lx_off;
			tok_line = lx_line;
			tok_col  = lx_col;
			tok_len  = 16'd1;
			if (is_digit(b)) begin
				lx_phase = stok_pkg::PH_NUM;
			end else if (is_name(b)) begin
				name_buf[0] = b;
				lx_phase    = stok_pkg::PH_IDENT;
			end else if (b == stok_pkg::CH_QUOTE) begin
				// The string token covers its contents, not the opening quote.
				tok_off  = sat_inc(lx_off);
				tok_len  = 16'd0;
				lx_phase = stok_pkg::PH_STR;
			end else begin
				case (b)
					";": put_tok(stok_pkg::TK_SEMI);
					"+": put_tok(stok_pkg::TK_PLUS);
					"*": put_tok(stok_pkg::TK_STAR);
					"(": put_tok(stok_pkg::TK_LPAREN);
					")": put_tok(stok_pkg::TK_RPAREN);
					"{": put_tok(stok_pkg::TK_LBRACE);
					"}": put_tok(stok_pkg::TK_RBRACE);
					"[": put_tok(stok_pkg::TK_LBRACKET);
					"]": put_tok(stok_pkg::TK_RBRACKET);
					",": put_tok(stok_pkg::TK_COMMA);
					":": put_tok(stok_pkg::TK_COLON);
					"-": lx_phase = stok_pkg::PH_MINUS;
					"=": lx_phase = stok_pkg::PH_EQ;
					"!": lx_phase = stok_pkg::PH_BANG;
					"<": lx_phase = stok_pkg::PH_LT;
					">": lx_phase = stok_pkg::PH_GT;
					"&": lx_phase = stok_pkg::PH_AMP;
					"|": lx_phase = stok_pkg::PH_BAR;
					"/": lx_phase = stok_pkg::PH_SLASH;
					default: begin
						put_tok(stok_pkg::TK_BADCHAR);
						lx_phase = stok_pkg::PH_ERROR;
					end
				endcase
			end
			step_over();
		end
	endtask

	// Second byte after an operator starter.
	task automatic lex_pending(input logic [7:0] b);
		logic [7:0]          c1, c2;
		stok_pkg::tok_kind_t k1, k2;
		logic                has2;
		has2 = 1'b0;
		c2   = 8'h00;
		k2   = stok_pkg::TK_END;
		case (lx_phase)
			stok_pkg::PH_MINUS: begin c1 = ">"; k1 = stok_pkg::TK_ARROW;  end
			stok_pkg::PH_EQ:    begin c1 = "="; k1 = stok_pkg::TK_EQ;     end
			stok_pkg::PH_BANG:  begin c1 = "="; k1 = stok_pkg::TK_NE;     end
			stok_pkg::PH_LT: begin
				c1 = "<"; k1 = stok_pkg::TK_SHL; has2 = 1'b1; c2 = "="; k2 = stok_pkg::TK_LE;
			end
			stok_pkg::PH_GT: begin
				c1 = ">"; k1 = stok_pkg::TK_SHR; has2 = 1'b1; c2 = "="; k2 = stok_pkg::TK_GE;
			end
			stok_pkg::PH_AMP:   begin c1 = "&"; k1 = stok_pkg::TK_ANDAND; end
			stok_pkg::PH_BAR:   begin c1 = "|"; k1 = stok_pkg::TK_OROR;   end
			default:            begin c1 = "/"; k1 = stok_pkg::TK_SLASH;  end
		endcase
		if (lx_phase == stok_pkg::PH_SLASH && b == c1) begin
			step_over();
			lx_phase = stok_pkg::PH_COMMENT;
		end else if (b == c1 || (has2 && b == c2)) begin
			step_over();
			tok_len = 16'd2;
			if (b == c1)
				put_tok(k1);
			else
				put_tok(k2);
			lx_phase = stok_pkg::PH_IDLE;
		end else begin
			put_tok(lone_kind(lx_phase));
			lx_phase = stok_pkg::PH_IDLE;
			lex_fresh(b);
		end
	endtask

	// Works out the tokens that one accepted transaction causes.
	task automatic lex_step(input logic m, input logic [7:0] b);
		stok_pkg::token_t t;
		step_out.delete();
		if (m) begin
			case (lx_phase)
				stok_pkg::PH_NUM:   put_tok(stok_pkg::TK_NUMBER);
				stok_pkg::PH_IDENT: put_tok(name_kind());
				stok_pkg::PH_STR:   put_tok(stok_pkg::TK_UNTERM);
				stok_pkg::PH_IDLE, stok_pkg::PH_COMMENT, stok_pkg::PH_ERROR: ;
				default:            put_tok(lone_kind(lx_phase));
			endcase
			put(stok_pkg::TK_END, lx_off, 16'd0, lx_line, lx_col);
			lex_clear();
		end else begin
			case (lx_phase)
				stok_pkg::PH_IDLE:  lex_fresh(b);
				stok_pkg::PH_ERROR: ;
				stok_pkg::PH_NUM: begin
					if (is_digit(b)) begin
						tok_len = sat_inc(tok_len);
						step_over();
					end else begin
						put_tok(stok_pkg::TK_NUMBER);
						lx_phase = stok_pkg::PH_IDLE;
						lex_fresh(b);
					end
				end
				stok_pkg::PH_IDENT: begin
					if (is_name(b) || is_digit(b)) begin
						if (tok_len < stok_pkg::KW_CHARS)
							name_buf[int'(tok_len)] = b;
						tok_len = sat_inc(tok_len);
						step_over();
					end else begin
						put_tok(name_kind());
						lx_phase = stok_pkg::PH_IDLE;
						lex_fresh(b);
					end
				end
				stok_pkg::PH_STR: begin
					// A newline inside a string is plain content.
					if (b == stok_pkg::CH_QUOTE) begin
						put_tok(stok_pkg::TK_STRING);
						lx_phase = stok_pkg::PH_IDLE;
					end else begin
						tok_len = sat_inc(tok_len);
					end
					step_over();
				end
				stok_pkg::PH_COMMENT: begin
					if (b == stok_pkg::CH_LF) begin
						lx_phase = stok_pkg::PH_IDLE;
						lex_fresh(b);
					end else begin
						step_over();
					end
				end
				default: lex_pending(b);
			endcase
		end
		foreach (step_out[i]) begin
			t          = step_out[i];
			t.run_last = (i == step_out.size() - 1);
			tokens_due.insert(tokens_due.size(), t);
		end
	endtask

	// ------------------------------------------------------------------------
	// Stimulus builders
	// ------------------------------------------------------------------------

	task automatic add_item(input logic m, input logic [7:0] b, input logic r);
		src_item_t it;
		it.mode      = m;
		it.text_byte = b;
		it.rush      = r;
		source_bytes.insert(source_bytes.size(), it);
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_item(1'b0, s[i], 1'b0);
	endtask

	task automatic add_pick(input string set);
		add_item(1'b0, set[$urandom_range(0, set.len() - 1)], 1'b0);
	endtask

	// The byte that goes with an end marker is ignored, so it is random.
	task automatic add_end();
		add_item(1'b1, 8'($urandom_range(0, 255)), 1'b0);
	endtask

	function automatic logic [7:0] any_but(input logic [7:0] x);
		logic [7:0] v;
		do
			v = 8'($urandom_range(0, 255));
		while (v == x);
		return v;
	endfunction

	// One token of random shape. The last token of a source may be left open.
	task automatic add_token(input bit last);
		int n;
		case ($urandom_range(0, 9))
			0, 1: begin
				n = $urandom_range(1, 5);
				repeat (n) add_pick(digit_chars);
			end
			2: begin
				add_pick(name_chars);
				n = $urandom_range(0, 11);
				repeat (n) add_pick({name_chars, digit_chars});
			end
			3, 4: begin
				add_text(kw_words[$urandom_range(0, 11)]);
				if ($urandom_range(0, 3) == 0)
					add_pick(name_chars);
			end
			5: begin
				add_item(1'b0, stok_pkg::CH_QUOTE, 1'b0);
				n = $urandom_range(0, 6);
				repeat (n) add_item(1'b0, any_but(stok_pkg::CH_QUOTE), 1'b0);
				if (!(last && $urandom_range(0, 2) == 0))
					add_item(1'b0, stok_pkg::CH_QUOTE, 1'b0);
			end
			6, 7: add_text(op_words[$urandom_range(0, 27)]);
			8: begin
				add_text("//");
				n = $urandom_range(0, 8);
				repeat (n) add_item(1'b0, any_but(stok_pkg::CH_LF), 1'b0);
				if (!last)
					add_item(1'b0, stok_pkg::CH_LF, 1'b0);
			end
			default: add_item(1'b0, $urandom_range(0, 1) ? stok_pkg::CH_TAB : stok_pkg::CH_CR,
				1'b0);
		endcase
	endtask

	// A source is a run of well-formed tokens with blanks in between, now and
	// then a stray byte that may throw the scanner into its error phase.
	task automatic add_source();
		int nt;
		nt = $urandom_range(1, 16);
		for (int t = 0; t < nt; t++) begin
			add_token(t == nt - 1);
			case ($urandom_range(0, 3))
				1: add_item(1'b0, stok_pkg::CH_SPACE, 1'b0);
				2: add_item(1'b0, stok_pkg::CH_LF, 1'b0);
				3: add_item(1'b0, $urandom_range(0, 1) ? stok_pkg::CH_TAB : stok_pkg::CH_CR,
					1'b0);
				default: ;
			endcase
			if ($urandom_range(0, 39) == 0)
				add_item(1'b0, 8'($urandom_range(0, 255)), 1'b0);
		end
		add_end();
	endtask

	// ------------------------------------------------------------------------
	// Clock, driver and monitor
	// ------------------------------------------------------------------------

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Source side. A payload stays put until it is taken; gaps only open
	// after a transaction, never under a stalled payload.
	always @(negedge clk) begin : src_drive
		bit squeezing;
		squeezing = bytes_taken >= squeeze_at && bytes_taken < squeeze_at + 40;
		if (arst_n && !(src_valid && !src_took)) begin
			if (src_gap != 0) begin
				src_gap = src_gap - 1;
				src_valid <= 1'b0;
			end else if (source_bytes.size() >= TAIL_ITEMS && !squeezing
					&& !source_bytes[0].rush && $urandom_range(0, 7) == 0) begin
				src_gap = $urandom_range(0, 15);
				src_valid <= 1'b0;
			end else if (source_bytes.size() != 0) begin
				src_valid <= 1'b1;
				mode      <= source_bytes[0].mode;
				text_byte <= source_bytes[0].text_byte;
				void'(source_bytes.pop_front());
			end else begin
				src_valid <= 1'b0;
			end
		end
	end

	// Token side. Besides the short random stalls there is one long hold-off
	// that lets both internal queues fill so that src_stall has to rise.
	always @(negedge clk) begin : sink_drive
		if (!squeezed && bytes_taken >= squeeze_at) begin
			squeezed  = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			tok_stall <= 1'b1;
		end else if (source_bytes.size() < TAIL_ITEMS) begin
			tok_stall <= 1'b0;
		end else if (sink_gap != 0) begin
			sink_gap = sink_gap - 1;
			tok_stall <= 1'b1;
		end else if ($urandom_range(0, 7) == 0) begin
			sink_gap = $urandom_range(0, 15);
			tok_stall <= 1'b1;
		end else begin
			tok_stall <= 1'b0;
		end
	end

	function automatic void check_field(input string what, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d actual %0d", $time, what, want, got);
			mismatches++;
		end
	endfunction

	// Outputs are sampled at the rising edge; the token channel is checked
	// before the source byte of the same edge is scanned.
	always @(posedge clk) begin : observe
		stok_pkg::token_t due;
		if (!arst_n) begin
			src_took <= 1'b0;
		end else begin
			if (tok_valid && !tok_stall) begin
				if (tokens_due.size() == 0) begin
					$display("%0t: token expected none actual kind %0d at offset %0d",
						$time, kind, start_offset);
					mismatches++;
				end else begin
					due = tokens_due.pop_front();
					check_field("kind", 16'(due.kind), 16'(kind));
					check_field("start_offset", due.start_offset, start_offset);
					check_field("text_length", due.text_length, text_length);
					check_field("line_number", due.line_number, line_number);
					check_field("column_number", due.column_number, column_number);
					check_field("run_last", 16'(due.run_last), 16'(run_last));
				end
			end
			if (src_valid && !src_stall) begin
				lex_step(mode, text_byte);
				bytes_taken++;
			end
			src_took <= src_valid && !src_stall;
		end
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || (src_valid && !src_stall) || (tok_valid && !tok_stall)) begin
			idle_run = 0;
		end else begin
			idle_run = idle_run + 1;
			if (idle_run == STALL_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------

	initial begin
		int base;
		lex_clear();

		// Directed sources. An empty source gives END alone.
		add_end();
		// Two-character operators, and a name still open at the end marker.
		add_text("a<=b<<c>=d>>e!=f==g&&h||i->j k");
		add_end();
		// Every single character and every starter followed by a byte that
		// does not pair with it; a single character after a starter gives two tokens.
		add_text("+-*/(){}[],:;=!<>&|");
		add_end();
		// Newline inside a string, an empty string, a number closed by the end.
		add_text("\"ab\ncd\" x \"\" 7");
		add_end();
		// Line comment, lone slash, and a comment still open at the end.
		add_text("// note\n 12 / 3 //");
		add_end();
		// Names at and beyond the buffer length, then an open string.
		add_text("continue continuex returnsx fun_ if9 \"op\nen");
		add_end();
		// Blanks and a semicolon, then a bad character after which everything is dropped.
		add_item(1'b0, stok_pkg::CH_TAB, 1'b0);
		add_item(1'b0, stok_pkg::CH_CR, 1'b0);
		add_text(" ; @ dropped \"x\" 5");
		add_end();
		// NUL and bytes with the top bit set are bad characters too.
		add_item(1'b0, 8'h00, 1'b0);
		add_text("x");
		add_end();
		add_item(1'b0, 8'hFF, 1'b0);
		add_end();
		add_item(1'b0, 8'h80, 1'b0);
		add_text("1");
		add_end();
		// A starter left pending at the end marker.
		add_text("-");
		add_end();

		base = source_bytes.size();
		squeeze_at = base + 300;
		while (source_bytes.size() < base + RANDOM_ITEMS)
			add_source();
		n_items = source_bytes.size();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (bytes_taken < n_items || tokens_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && tokens_due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
